// File: src/motion_segment_record_replay_top_assert.svh
// assertion macros for the motion segment record and replay block
`ifndef MOTION_SEGMENT_RECORD_REPLAY_TOP_ASSERT_SVH
`define MOTION_SEGMENT_RECORD_REPLAY_TOP_ASSERT_SVH

// plain property, checked on the rising edge, off during reset
`define MSRR_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// same-cycle implication, checked on the rising edge, off during reset
`define MSRR_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) else $error(msg);

`endif

// File: src/msrr_pkg.sv
// types and constants of the motion segment record and replay block
`default_nettype none

package msrr_pkg;

  typedef enum logic [1:0] {
    RS_IDLE = 2'd0,
    RS_REC  = 2'd1,
    RS_PLAY = 2'd2
  } run_state_t;

  typedef enum logic [1:0] {
    MODE_RECORD  = 2'd0,
    MODE_TICK    = 2'd1,
    MODE_COMMAND = 2'd2,
    MODE_BLOCK   = 2'd3
  } mode_t;

  localparam logic [7:0] CMD_TOGGLE_REC = 8'h01;
  localparam logic [7:0] CMD_LOOP_PLAY  = 8'h02;
  localparam logic [7:0] CMD_STOP       = 8'h00;
  localparam logic [7:0] CMD_STOP_ALT   = 8'hFF;

  localparam logic signed [1:0] DIR_FWD  = 2'sb01;
  localparam logic signed [1:0] DIR_REV  = 2'sb11;
  localparam logic signed [1:0] DIR_STOP = 2'sb00;

  localparam logic [30:0] LEN_MAX     = 31'h7FFF_FFFF;
  localparam logic [8:0]  DT_MIN      = 9'd1;
  localparam logic [8:0]  DT_MAX      = 9'd500;
  localparam logic [15:0] PAUSE_RESET = 16'd3000;

endpackage

`default_nettype wire

// File: src/motion_segment_record_replay_top.sv
// top level of the motion segment record and replay block
`default_nettype none

`include "motion_segment_record_replay_top_assert.svh"

// Records encoder motion as a table of direction segments and replays it.
// The path of a request runs through registers in this order:
// the request is captured in an input register, all of its work is done
// in one pass of compares and adds against registered state, and the
// result lands in an output register, so one request per cycle is
// sustained while the output side takes results; a stalled result holds
// the output register and the input register still takes one more
// request. The longest path is the 32-bit count subtract, magnitude
// select and length add or compare. The segment table is a memory with
// one write and one registered read port; the read is taken from the
// next replay index, while the first entry and the most recently
// written entry also sit in registers, so recording and the start of a
// replay never wait on the read. The table is not cleared after reset:
// only entries below the segment count are read. The pause register is
// written through the cfg channel, which is always ready.
module motion_segment_record_replay_top import msrr_pkg::*; #(
  parameter int MAX_SEGMENTS = 32,
  localparam int CW = $clog2(MAX_SEGMENTS + 1),
  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1
) (
  input  wire                  clk,
  input  wire                  rst,
  // request channel
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire  [1:0]           mode,
  input  wire  signed [31:0]   encoder_count,
  input  wire  [15:0]          dt_ms,
  input  wire  signed [7:0]    command,
  input  wire                  block_flag,
  // result channel
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic                 drive_valid,
  output logic signed [1:0]    drive_dir,
  output logic                 play_done,
  output logic [1:0]           run_state,
  output logic [CW-1:0]        segment_total,
  output logic [CW-1:0]        play_position,
  output logic                 pausing,
  // pause register write
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire  [15:0]          cfg_data
);

  // input register
  logic        in_q_valid;
  mode_t       in_mode;
  logic [31:0] in_count;
  logic [15:0] in_dt;
  logic [7:0]  in_cmd;
  logic        in_blk;

  logic advance;
  logic in_accept;

  // block state
  run_state_t     run_mode, run_mode_next;
  logic [31:0]    prev_count, prev_count_next;
  logic           record_primed, record_primed_next;
  logic [CW-1:0]  seg_used, seg_used_next;
  logic [CW-1:0]  play_index, play_index_next;
  logic [31:0]    play_origin, play_origin_next;
  logic           play_primed, play_primed_next;
  logic           loop_on, loop_on_next;
  logic           blocked_now, blocked_now_next;
  logic           in_pause, in_pause_next;
  logic [16:0]    pause_elapsed, pause_elapsed_next;
  logic [15:0]    pause_ms;

  // cached copies of table entries: first one and most recent one
  logic           first_dir, first_dir_next;
  logic [30:0]    first_len, first_len_next;
  logic           last_dir, last_dir_next;
  logic [30:0]    last_len, last_len_next;

  // segment table, direction in the top bit
  logic [31:0]    seg_mem [MAX_SEGMENTS];
  logic           rd_dir;
  logic [30:0]    rd_len;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [31:0]    wr_data;

  // per-request results
  logic              drv_valid;
  logic signed [1:0] drv_dir;
  logic              done;

  // record datapath
  logic [31:0]   rec_diff, rec_ndiff, rec_mag;
  logic          rec_neg, rec_dir;
  logic [30:0]   rec_step, rec_sum_sat;
  logic [31:0]   rec_sum;
  logic          seg_full;
  logic [CW-1:0] seg_last;

  // replay datapath
  logic [31:0]   origin_eff, trav_fwd, trav_rev, trav;
  logic          cur_dir;
  logic [30:0]   cur_len;
  logic          reached;
  logic [8:0]    dt_clamped;
  logic [16:0]   pause_sum;
  logic          pause_over;
  logic [CW-1:0] index_inc;

  // handshake: process when a request waits and the result slot frees up
  assign advance   = in_q_valid && (!out_valid || !out_stall);
  assign in_stall  = in_q_valid && !advance;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_accept) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_mode  <= mode_t'(mode);
      in_count <= encoder_count;
      in_dt    <= dt_ms;
      in_cmd   <= command;
      in_blk   <= block_flag;
    end
  end

  // record sample: signed difference, magnitude with saturation
  assign rec_diff    = in_count - prev_count;
  assign rec_ndiff   = prev_count - in_count;
  assign rec_neg     = rec_diff[31];
  assign rec_dir     = !rec_neg;
  assign rec_mag     = rec_neg ? rec_ndiff : rec_diff;
  assign rec_step    = rec_mag[31] ? LEN_MAX : rec_mag[30:0];
  assign rec_sum     = {1'b0, last_len} + {1'b0, rec_step};
  assign rec_sum_sat = rec_sum[31] ? LEN_MAX : rec_sum[30:0];
  assign seg_full    = (seg_used == CW'(MAX_SEGMENTS));
  assign seg_last    = seg_used - CW'(1);

  // play tick: distance travelled since the segment began
  assign origin_eff = play_primed ? play_origin : in_count;
  assign trav_fwd   = in_count - origin_eff;
  assign trav_rev   = origin_eff - in_count;
  assign trav       = trav_fwd[31] ? trav_rev : trav_fwd;
  assign cur_dir    = (play_index == '0) ? first_dir : rd_dir;
  assign cur_len    = (play_index == '0) ? first_len : rd_len;
  assign reached    = (trav >= {1'b0, cur_len});
  assign index_inc  = play_index + CW'(1);

  always_comb begin
    if (in_dt == 16'd0) begin
      dt_clamped = DT_MIN;
    end else if (in_dt > {7'd0, DT_MAX}) begin
      dt_clamped = DT_MAX;
    end else begin
      dt_clamped = in_dt[8:0];
    end
  end

  assign pause_sum  = pause_elapsed + {8'd0, dt_clamped};
  assign pause_over = (pause_sum >= {1'b0, pause_ms});

  // next state and result of the request in the input register
  always_comb begin
    run_mode_next      = run_mode;
    prev_count_next    = prev_count;
    record_primed_next = record_primed;
    seg_used_next      = seg_used;
    play_index_next    = play_index;
    play_origin_next   = play_origin;
    play_primed_next   = play_primed;
    loop_on_next       = loop_on;
    blocked_now_next   = blocked_now;
    in_pause_next      = in_pause;
    pause_elapsed_next = pause_elapsed;
    first_dir_next     = first_dir;
    first_len_next     = first_len;
    last_dir_next      = last_dir;
    last_len_next      = last_len;
    wr_en              = 1'b0;
    wr_addr            = seg_used[AW-1:0];
    wr_data            = {rec_dir, rec_step};
    drv_valid          = 1'b0;
    drv_dir            = DIR_STOP;
    done               = 1'b0;

    if (advance) begin
      case (in_mode)
        MODE_RECORD: begin
          if (run_mode == RS_REC) begin
            prev_count_next = in_count;
            if (!record_primed) begin
              record_primed_next = 1'b1;
            end else if (rec_diff != 32'd0) begin
              if (seg_used == '0) begin
                // first segment of a fresh recording
                wr_en          = 1'b1;
                wr_addr        = '0;
                first_dir_next = rec_dir;
                first_len_next = rec_step;
                last_dir_next  = rec_dir;
                last_len_next  = rec_step;
                seg_used_next  = CW'(1);
              end else if (last_dir == rec_dir) begin
                // same direction: grow the open segment
                wr_en         = 1'b1;
                wr_addr       = seg_last[AW-1:0];
                wr_data       = {last_dir, rec_sum_sat};
                last_len_next = rec_sum_sat;
                if (seg_used == CW'(1)) begin
                  first_len_next = rec_sum_sat;
                end
              end else if (!seg_full) begin
                // reversal opens a new segment
                wr_en         = 1'b1;
                last_dir_next = rec_dir;
                last_len_next = rec_step;
                seg_used_next = seg_used + CW'(1);
              end else begin
                run_mode_next = RS_IDLE;
              end
            end
          end
        end

        MODE_TICK: begin
          if (blocked_now) begin
            drv_valid = 1'b1;
          end else if (run_mode == RS_PLAY) begin
            if (play_index >= seg_used) begin
              drv_valid = 1'b1;
              if (loop_on && (seg_used != '0)) begin
                play_index_next    = '0;
                play_primed_next   = 1'b0;
                in_pause_next      = 1'b0;
                pause_elapsed_next = '0;
              end else begin
                run_mode_next = RS_IDLE;
                done          = 1'b1;
              end
            end else if (in_pause) begin
              drv_valid          = 1'b1;
              pause_elapsed_next = pause_sum;
              if (pause_over) begin
                in_pause_next      = 1'b0;
                pause_elapsed_next = '0;
                play_primed_next   = 1'b0;
              end
            end else begin
              if (!play_primed) begin
                play_origin_next = in_count;
                play_primed_next = 1'b1;
              end
              drv_valid = 1'b1;
              if (reached) begin
                if (index_inc < seg_used) begin
                  play_index_next    = index_inc;
                  play_primed_next   = 1'b0;
                  in_pause_next      = 1'b1;
                  pause_elapsed_next = '0;
                end else if (loop_on) begin
                  play_index_next    = '0;
                  play_primed_next   = 1'b0;
                  in_pause_next      = 1'b1;
                  pause_elapsed_next = '0;
                end else begin
                  run_mode_next = RS_IDLE;
                  done          = 1'b1;
                end
              end else begin
                drv_dir = cur_dir ? DIR_FWD : DIR_REV;
              end
            end
          end
        end

        MODE_COMMAND: begin
          if (in_cmd == CMD_TOGGLE_REC) begin
            if (run_mode == RS_REC) begin
              run_mode_next = RS_IDLE;
            end else begin
              if (run_mode == RS_PLAY) begin
                in_pause_next      = 1'b0;
                pause_elapsed_next = '0;
                drv_valid          = 1'b1;
              end
              loop_on_next       = 1'b0;
              run_mode_next      = RS_REC;
              seg_used_next      = '0;
              record_primed_next = 1'b0;
            end
          end else if (in_cmd == CMD_LOOP_PLAY) begin
            if (seg_used != '0) begin
              loop_on_next       = 1'b1;
              run_mode_next      = RS_PLAY;
              play_index_next    = '0;
              play_primed_next   = 1'b0;
              in_pause_next      = 1'b0;
              pause_elapsed_next = '0;
            end
          end else if ((in_cmd == CMD_STOP) || (in_cmd == CMD_STOP_ALT)) begin
            loop_on_next = 1'b0;
            if (run_mode == RS_PLAY) begin
              run_mode_next      = RS_IDLE;
              in_pause_next      = 1'b0;
              pause_elapsed_next = '0;
              drv_valid          = 1'b1;
            end
          end
        end

        MODE_BLOCK: begin
          blocked_now_next = in_blk;
        end

        default: begin
          blocked_now_next = blocked_now;
        end
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode      <= RS_IDLE;
      prev_count    <= '0;
      record_primed <= 1'b0;
      seg_used      <= '0;
      play_index    <= '0;
      play_origin   <= '0;
      play_primed   <= 1'b0;
      loop_on       <= 1'b0;
      blocked_now   <= 1'b0;
      in_pause      <= 1'b0;
      pause_elapsed <= '0;
    end else begin
      run_mode      <= run_mode_next;
      prev_count    <= prev_count_next;
      record_primed <= record_primed_next;
      seg_used      <= seg_used_next;
      play_index    <= play_index_next;
      play_origin   <= play_origin_next;
      play_primed   <= play_primed_next;
      loop_on       <= loop_on_next;
      blocked_now   <= blocked_now_next;
      in_pause      <= in_pause_next;
      pause_elapsed <= pause_elapsed_next;
    end
  end

  // cached entries, valid whenever the segment count covers them
  always_ff @(posedge clk) begin
    first_dir <= first_dir_next;
    first_len <= first_len_next;
    last_dir  <= last_dir_next;
    last_len  <= last_len_next;
  end

  // table write, and registered read at the coming replay index
  always_ff @(posedge clk) begin
    if (wr_en) begin
      seg_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    {rd_dir, rd_len} <= seg_mem[play_index_next[AW-1:0]];
  end

  // pause register
  always_ff @(posedge clk) begin
    if (rst) begin
      pause_ms <= PAUSE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      pause_ms <= cfg_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive_valid   <= drv_valid;
      drive_dir     <= drv_dir;
      play_done     <= done;
      run_state     <= run_mode_next;
      segment_total <= seg_used_next;
      play_position <= play_index_next;
      pausing       <= in_pause_next;
    end
  end

  `MSRR_ASSERT_IMP(a_play_has_segments, clk, rst, out_valid && (run_state == RS_PLAY),
    segment_total != '0, "replay running with an empty segment table")
  `MSRR_ASSERT_IMP(a_done_stops, clk, rst, out_valid && play_done,
    drive_valid && (drive_dir == DIR_STOP) && (run_state == RS_IDLE), "finish without stop")
  `MSRR_ASSERT_IMP(a_pause_in_play, clk, rst, out_valid && pausing,
    run_state == RS_PLAY, "pause flagged outside replay")
  `MSRR_ASSERT(a_request_held, clk, rst, (in_q_valid && !advance) |=> in_q_valid,
    "held request dropped")

endmodule

`default_nettype wire
